FILE: hdl/mqurc_pkg.sv
// Shared types, constants and helper functions for the modem response line parser.
`timescale 1ns / 1ps

package mqurc_pkg;

    localparam int unsigned POSITION_BITS = 16;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    localparam int unsigned NUM_PFX = 5;
    localparam int unsigned PFX_MAX = 18;
    localparam int unsigned LENGTH_LIMIT = 65535;
    localparam int unsigned DECIMAL_BASE = 10;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    typedef enum logic [2:0] {
        KIND_NONE         = 3'd0,
        KIND_CONNECTED    = 3'd1,
        KIND_DISCONNECTED = 3'd2,
        KIND_SUB          = 3'd3,
        KIND_SUBRECV      = 3'd4,
        KIND_CONN         = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        CP_WAIT_COMMA  = 2'd0,
        CP_FIELD_START = 2'd1,
        CP_IN_FIELD    = 2'd2,
        CP_CLOSED      = 2'd3
    } t_conn_phase;

    // Prefix text, right aligned: the last character sits in the low byte.
    localparam logic [PFX_MAX*8-1:0] PFX_TEXT [NUM_PFX] = '{
        (PFX_MAX*8)'("+MQTTCONNECTED:"),
        (PFX_MAX*8)'("+MQTTDISCONNECTED:"),
        (PFX_MAX*8)'("+MQTTSUB:"),
        (PFX_MAX*8)'("+MQTTSUBRECV:"),
        (PFX_MAX*8)'("+MQTTCONN:")
    };
    localparam logic [4:0] PFX_LEN [NUM_PFX] = '{5'd15, 5'd18, 5'd9, 5'd13, 5'd10};
    localparam t_kind PFX_KIND [NUM_PFX] = '{
        KIND_CONNECTED, KIND_DISCONNECTED, KIND_SUB, KIND_SUBRECV, KIND_CONN
    };

    // One byte as it is handed to the parsing units.
    typedef struct packed {
        logic                     take;   // byte updates the line state
        logic                     clear;  // line ends: return to the reset state
        logic [7:0]               data;
        logic [POSITION_BITS-1:0] pos;    // index of this byte
        logic [POSITION_BITS-1:0] n_pos;  // byte count after this byte
    } t_step;

    typedef struct packed {
        logic        conn_ok;
        logic [7:0]  conn_state;
        logic        sub_ok;
        logic [15:0] payload_offset;
        logic [15:0] payload_len;
    } t_field_res;

    typedef struct packed {
        t_kind       line_kind;
        logic        is_urc;
        logic        conn_ok;
        logic [7:0]  conn_state;
        logic        sub_ok;
        logic [15:0] payload_offset;
        logic [15:0] payload_len;
    } t_result;

    // Character p of prefix idx; only meaningful for p below the prefix length.
    function automatic logic [7:0] pfx_char(input logic [2:0] idx, input logic [4:0] p);
        logic [4:0] off;
        off = PFX_LEN[idx] - 5'd1 - p;
        return PFX_TEXT[idx][{off, 3'b000} +: 8];
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage

FILE: hdl/mqurc_in_if.sv
// Input channel carrying one line byte per word.
`timescale 1ns / 1ps

interface mqurc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       line_end;

    modport source (output valid, output line_byte, output line_end, input ready);
    modport sink   (input valid, input line_byte, input line_end, output ready);
endinterface

FILE: hdl/mqurc_out_if.sv
// Output channel carrying one parse result per word.
`timescale 1ns / 1ps

interface mqurc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  line_kind;
    logic        is_urc;
    logic        conn_ok;
    logic [7:0]  conn_state;
    logic        sub_ok;
    logic [15:0] payload_offset;
    logic [15:0] payload_len;

    modport source (output valid, output line_kind, output is_urc, output conn_ok,
                    output conn_state, output sub_ok, output payload_offset,
                    output payload_len, input ready);
    modport sink   (input valid, input line_kind, input is_urc, input conn_ok,
                    input conn_state, input sub_ok, input payload_offset,
                    input payload_len, output ready);
endinterface

FILE: hdl/at_mqtt_urc_line_parser.sv
// A line's last byte passes through the input register, and its result word is written into the result register.
// Throughput: one byte word per cycle, except that a line-ending byte waits while a result is still untaken.
// The input register accepts a new word while a finished result waits for its sink, unless it holds a line end.
// A result word is produced only for the word that carries line_end.
// Reset is synchronous, active low, and returns all line state to its idle values.
`timescale 1ns / 1ps

module at_mqtt_urc_line_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mqurc_in_if.sink    i_line,
    mqurc_out_if.source o_result
);

    // The design is a two-register pipeline. The input register captures one
    // byte word. From there the byte is folded into the running line
    // state (prefix matcher and field parser), and when it is the last byte of
    // the line the finished result is written into the result register and the
    // line state returns to its idle values in the same edge.

    logic                               r_in_valid;
    logic [7:0]                         r_in_byte;
    logic                               r_in_end;

    logic [mqurc_pkg::POSITION_BITS-1:0] r_pos;
    logic                               r_ovf;

    logic                               r_out_valid;
    mqurc_pkg::t_result                 r_out;

    logic                               advance;
    logic                               line_done;
    logic                               overflow_now;
    mqurc_pkg::t_step                   step;
    mqurc_pkg::t_kind                   kind;
    mqurc_pkg::t_field_res              fields;
    mqurc_pkg::t_result                 n_out;

    // A byte that does not end a line never waits; a line-ending byte waits
    // only while the result register still holds an untaken result.
    assign advance   = r_in_valid && (!r_in_end || !r_out_valid || o_result.ready);
    assign line_done = advance && r_in_end;

    assign i_line.ready = !r_in_valid || advance;

    // Once the position counter is saturated, further bytes mark the line as
    // too long and are no longer parsed.
    assign overflow_now = r_ovf || (r_pos == mqurc_pkg::POS_MAX);

    always_comb begin
        step.take  = advance && !overflow_now;
        step.clear = line_done;
        step.data  = r_in_byte;
        step.pos   = r_pos;
        step.n_pos = r_pos + mqurc_pkg::POSITION_BITS'(1);
    end

    mqurc_prefix u_prefix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_kind  (kind)
    );

    mqurc_fields u_fields (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_res   (fields)
    );

    // Assemble the result. A line that ran past the position limit reports
    // kind none with every other field cleared.
    always_comb begin
        n_out                = '0;
        n_out.line_kind      = mqurc_pkg::KIND_NONE;
        if (!overflow_now) begin
            n_out.line_kind = kind;
            n_out.is_urc    = (kind == mqurc_pkg::KIND_CONNECTED) ||
                              (kind == mqurc_pkg::KIND_DISCONNECTED) ||
                              (kind == mqurc_pkg::KIND_SUB) ||
                              (kind == mqurc_pkg::KIND_SUBRECV);
            if (kind == mqurc_pkg::KIND_CONN && fields.conn_ok) begin
                n_out.conn_ok    = 1'b1;
                n_out.conn_state = fields.conn_state;
            end
            if (kind == mqurc_pkg::KIND_SUBRECV && fields.sub_ok) begin
                n_out.sub_ok         = 1'b1;
                n_out.payload_offset = fields.payload_offset;
                n_out.payload_len    = fields.payload_len;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_line.valid && i_line.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_line.valid && i_line.ready) begin
            r_in_byte <= i_line.line_byte;
            r_in_end  <= i_line.line_end;
        end
    end

    // Byte position and the too-long flag for the current line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || line_done) begin
            r_pos <= '0;
            r_ovf <= 1'b0;
        end else if (advance && !r_ovf) begin
            if (r_pos == mqurc_pkg::POS_MAX) begin
                r_ovf <= 1'b1;
            end else begin
                r_pos <= step.n_pos;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (line_done) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (line_done) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.line_kind      = r_out.line_kind;
    assign o_result.is_urc         = r_out.is_urc;
    assign o_result.conn_ok        = r_out.conn_ok;
    assign o_result.conn_state     = r_out.conn_state;
    assign o_result.sub_ok         = r_out.sub_ok;
    assign o_result.payload_offset = r_out.payload_offset;
    assign o_result.payload_len    = r_out.payload_len;

`ifndef SYNTHESIS
    // A successful subscription-receive parse only belongs to that line kind.
    a_sub_ok_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.sub_ok) |->
            (o_result.line_kind == mqurc_pkg::KIND_SUBRECV))
        else $error("sub_ok set on a line that is not a subscription receive");

    // A parsed connection state only belongs to a connection-state line.
    a_conn_ok_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.conn_ok) |->
            (o_result.line_kind == mqurc_pkg::KIND_CONN))
        else $error("conn_ok set on a line that is not a connection-state line");

    // A line that ran too long reports nothing.
    a_ovf_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (line_done && r_ovf) |=>
            (r_out.line_kind == mqurc_pkg::KIND_NONE && !r_out.is_urc &&
             !r_out.conn_ok && !r_out.sub_ok))
        else $error("overlong line produced a non-empty result");

    // The byte position restarts after every line end.
    a_pos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        line_done |=> (r_pos == '0 && !r_ovf))
        else $error("line position not cleared after line end");
`endif

endmodule

FILE: hdl/mqurc_prefix.sv
// Prefix matcher: tracks which fixed prefixes still match and picks the line kind.
`timescale 1ns / 1ps

module mqurc_prefix (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mqurc_pkg::t_step    i_step,
    output mqurc_pkg::t_kind    o_kind
);

    logic [mqurc_pkg::NUM_PFX-1:0] r_alive;
    logic [mqurc_pkg::NUM_PFX-1:0] n_alive;

    always_comb begin
        n_alive = r_alive;
        o_kind  = mqurc_pkg::KIND_NONE;
        for (int i = 0; i < mqurc_pkg::NUM_PFX; i++) begin
            if (i_step.take &&
                i_step.pos < mqurc_pkg::POSITION_BITS'(mqurc_pkg::PFX_LEN[i]) &&
                i_step.data != mqurc_pkg::pfx_char(3'(i), i_step.pos[4:0])) begin
                n_alive[i] = 1'b0;
            end
        end
        // Later prefixes take priority when more than one is complete.
        for (int i = 0; i < mqurc_pkg::NUM_PFX; i++) begin
            if (n_alive[i] &&
                i_step.n_pos >= mqurc_pkg::POSITION_BITS'(mqurc_pkg::PFX_LEN[i])) begin
                o_kind = mqurc_pkg::PFX_KIND[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_step.clear) begin
            r_alive <= '1;
        end else begin
            r_alive <= n_alive;
        end
    end

endmodule

FILE: hdl/mqurc_fields.sv
// Field parser: connection-state value, subscription length and payload count.
`timescale 1ns / 1ps

module mqurc_fields (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mqurc_pkg::t_step        i_step,
    output mqurc_pkg::t_field_res   o_res
);

    logic [1:0]                r_commas,  n_commas;
    logic [7:0]                r_conn,    n_conn;
    mqurc_pkg::t_conn_phase    r_phase,   n_phase;
    logic [16:0]               r_len,     n_len;
    logic                      r_seen,    n_seen;
    logic [15:0]               r_count,   n_count;
    logic [15:0]               r_start,   n_start;
    logic                      r_err_conn, n_err_conn;
    logic                      r_err_len,  n_err_len;

    logic       comma;
    logic       digit;
    logic [3:0] digit_val;
    logic [19:0] len_prod;

    always_comb begin
        comma      = (i_step.data == mqurc_pkg::CH_COMMA);
        digit      = mqurc_pkg::is_digit(i_step.data);
        digit_val  = 4'(i_step.data - mqurc_pkg::CH_ZERO);
        len_prod   = 20'(r_len) * 20'(mqurc_pkg::DECIMAL_BASE) + 20'(digit_val);

        n_commas   = r_commas;
        n_conn     = r_conn;
        n_phase    = r_phase;
        n_len      = r_len;
        n_seen     = r_seen;
        n_count    = r_count;
        n_start    = r_start;
        n_err_conn = r_err_conn;
        n_err_len  = r_err_len;

        if (i_step.take) begin
            case (r_phase)
                mqurc_pkg::CP_WAIT_COMMA: begin
                    if (comma) begin
                        n_phase = mqurc_pkg::CP_FIELD_START;
                    end
                end
                mqurc_pkg::CP_FIELD_START, mqurc_pkg::CP_IN_FIELD: begin
                    if (comma) begin
                        n_phase = mqurc_pkg::CP_CLOSED;
                    end else begin
                        n_phase = mqurc_pkg::CP_IN_FIELD;
                        if (digit) begin
                            n_conn = 8'(r_conn * 8'(mqurc_pkg::DECIMAL_BASE)) + 8'(digit_val);
                        end else begin
                            n_err_conn = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase

            if (comma && r_commas != 2'd3) begin
                n_commas = r_commas + 2'd1;
                if (r_commas == 2'd2) begin
                    n_start = 16'(i_step.n_pos);
                end
            end else if (r_commas == 2'd2) begin
                n_seen = 1'b1;
                if (!digit) begin
                    n_err_len = 1'b1;
                end else if (!r_err_len) begin
                    if (len_prod > 20'(mqurc_pkg::LENGTH_LIMIT)) begin
                        n_err_len = 1'b1;
                        n_len     = 17'(mqurc_pkg::LENGTH_LIMIT) + 17'd1;
                    end else begin
                        n_len = 17'(len_prod);
                    end
                end
            end else if (r_commas == 2'd3) begin
                if (r_count != 16'hFFFF) begin
                    n_count = r_count + 16'd1;
                end
            end
        end

        o_res.conn_ok        = (n_phase == mqurc_pkg::CP_IN_FIELD ||
                                n_phase == mqurc_pkg::CP_CLOSED) && !n_err_conn;
        o_res.conn_state     = n_conn;
        o_res.sub_ok         = (n_commas == 2'd3) && n_seen && !n_err_len &&
                               ({1'b0, n_count} == n_len);
        o_res.payload_offset = n_start;
        o_res.payload_len    = n_len[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_step.clear) begin
            r_commas   <= 2'd0;
            r_conn     <= 8'd0;
            r_phase    <= mqurc_pkg::CP_WAIT_COMMA;
            r_len      <= 17'd0;
            r_seen     <= 1'b0;
            r_count    <= 16'd0;
            r_start    <= 16'd0;
            r_err_conn <= 1'b0;
            r_err_len  <= 1'b0;
        end else begin
            r_commas   <= n_commas;
            r_conn     <= n_conn;
            r_phase    <= n_phase;
            r_len      <= n_len;
            r_seen     <= n_seen;
            r_count    <= n_count;
            r_start    <= n_start;
            r_err_conn <= n_err_conn;
            r_err_len  <= n_err_len;
        end
    end

endmodule
